/* src/arclru_pkg.sv */
// Shared types and constants for the associative result cache.
package arclru_pkg;

	// Store geometry.
	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 64;
	localparam int KEY_PORT_W = 64;
	localparam int STAMP_W    = 32;
	localparam int CNT_W      = 32;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int HW_W       = $clog2(ENTRIES + 1);
	localparam int CAP_W      = 5;
	localparam int HWC_W      = (HW_W > CAP_W) ? HW_W : CAP_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// Reset values of the configuration registers.
	localparam logic             ENABLE_RST   = 1'b1;
	localparam logic [CAP_W-1:0] CAPACITY_RST = CAP_W'(16);

	// Command codes.
	typedef enum logic [1:0] {
		CMD_GET   = 2'd0,
		CMD_SET   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE   = 1'b0,
		REG_CAPACITY = 1'b1
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK_RD,
		ST_LOOK_CMP,
		ST_EVICT_RD,
		ST_EVICT_CMP,
		ST_EVICT_DROP,
		ST_FILL,
		ST_DONE
	} state_t;

	// Operations of the shared compare unit.
	typedef enum logic {
		CMP_KEY_EQ,
		CMP_STAMP_LT
	} cmp_op_t;

	// One stored entry.
	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic                result;
		logic [STAMP_W-1:0]  stamp;
	} entry_t;

	// Request from the sequencer to the entry store.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} store_req_t;

	// Operands for the shared compare unit.
	typedef struct packed {
		cmp_op_t             op;
		logic [KEY_BITS-1:0] key_a;
		logic [KEY_BITS-1:0] key_b;
		logic [STAMP_W-1:0]  stamp_a;
		logic [STAMP_W-1:0]  stamp_b;
	} cmp_req_t;

endpackage

/* src/assoc_result_cache_lru.sv */
// Top level of the associative result cache with least-recently-used eviction.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    cmd, key_tag, store_value
//   out      output     out_valid / out_ready  hit, result_bit, hits_so_far, misses_so_far
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A get reads and compares each slot below the high-water count until a valid match. A
// set at capacity first scans those slots and drops the oldest stamp, then fills the first
// free slot. Clear, disabled commands and no-ops go straight to the final state. The scans
// share one read port and one compare unit.
// Reset clears the valid bits, counters and tick; the memory needs no clearing.
// in_ready is high only in idle, a result waiting on out_ready holds the final state,
// and configuration writes are always taken.
module assoc_result_cache_lru
	import arclru_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            cmd,
	input  logic [KEY_PORT_W-1:0] key_tag,
	input  logic                  store_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  hit,
	output logic                  result_bit,
	output logic [CNT_W-1:0]      hits_so_far,
	output logic [CNT_W-1:0]      misses_so_far,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic               enable_q;
	logic [CAP_W-1:0]   capacity_q;
	logic [ENTRIES-1:0] valid_q;
	logic [HW_W-1:0]    hw_q;
	logic [CNT_W-1:0]   hit_cnt_q;
	logic [CNT_W-1:0]   miss_cnt_q;
	logic [STAMP_W-1:0] tick_q;

	logic [KEY_BITS-1:0] key_q;
	logic                val_q;
	logic [HW_W-1:0]     idx_q;
	logic                have_q;
	logic [IDX_W-1:0]    pick_q;
	logic [STAMP_W-1:0]  best_q;
	logic                res_hit_q;
	logic                res_bit_q;

	logic               out_valid_q;
	logic               out_hit_q;
	logic               out_bit_q;
	logic [CNT_W-1:0]   out_hits_q;
	logic [CNT_W-1:0]   out_misses_q;

	store_req_t store_req;
	entry_t     rdata;
	cmp_req_t   cmp_req;
	logic       cmp_true;

	logic             in_acc;
	logic             out_free;
	logic             scan_end;
	logic             need_evict;
	logic             cur_valid;
	logic             fill_found;
	logic [IDX_W-1:0] fill_idx;

	arclru_store u_store (
		.clk   (clk),
		.req   (store_req),
		.rdata (rdata)
	);

	arclru_cmp u_cmp (
		.req    (cmp_req),
		.result (cmp_true)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign scan_end  = (idx_q >= hw_q);
	assign cur_valid = valid_q[idx_q[IDX_W-1:0]];
	assign need_evict = (HWC_W'(hw_q) >= HWC_W'(capacity_q));

	// First free slot over the whole store.
	always_comb begin
		fill_found = 1'b0;
		fill_idx   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				fill_found = 1'b1;
				fill_idx   = IDX_W'(i);
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (cmd_t'(cmd))
						CMD_GET: state_d = enable_q ? ST_LOOK_RD : ST_DONE;
						CMD_SET: begin
							if (!enable_q) begin
								state_d = ST_DONE;
							end else if (need_evict) begin
								state_d = ST_EVICT_RD;
							end else begin
								state_d = ST_FILL;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_LOOK_RD:    state_d = scan_end ? ST_DONE : ST_LOOK_CMP;
			ST_LOOK_CMP:   state_d = (cur_valid && cmp_true) ? ST_DONE : ST_LOOK_RD;
			ST_EVICT_RD:   state_d = scan_end ? ST_EVICT_DROP : ST_EVICT_CMP;
			ST_EVICT_CMP:  state_d = ST_EVICT_RD;
			ST_EVICT_DROP: state_d = ST_FILL;
			ST_FILL:       state_d = ST_DONE;
			ST_DONE:       state_d = out_free ? ST_IDLE : ST_DONE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// Store and compare-unit controls.
	always_comb begin
		store_req       = '0;
		store_req.raddr = idx_q[IDX_W-1:0];
		cmp_req         = '0;
		cmp_req.key_a   = rdata.key;
		cmp_req.key_b   = key_q;
		cmp_req.stamp_a = rdata.stamp;
		cmp_req.stamp_b = best_q;
		case (state_q)
			ST_LOOK_RD, ST_EVICT_RD: begin
				store_req.re = !scan_end;
			end
			ST_LOOK_CMP: begin
				cmp_req.op = CMP_KEY_EQ;
				// A hit refreshes the entry's stamp.
				store_req.we           = cur_valid && cmp_true;
				store_req.waddr        = idx_q[IDX_W-1:0];
				store_req.wdata.key    = rdata.key;
				store_req.wdata.result = rdata.result;
				store_req.wdata.stamp  = tick_q;
			end
			ST_EVICT_CMP: begin
				cmp_req.op = CMP_STAMP_LT;
			end
			ST_FILL: begin
				store_req.we           = fill_found;
				store_req.waddr        = fill_idx;
				store_req.wdata.key    = key_q;
				store_req.wdata.result = val_q;
				store_req.wdata.stamp  = tick_q;
			end
			default: begin
				store_req.re = 1'b0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= ENABLE_RST;
			capacity_q <= CAPACITY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_ENABLE:   enable_q   <= cfg_data[0];
				REG_CAPACITY: capacity_q <= cfg_data[CAP_W-1:0];
				default:      enable_q   <= enable_q;
			endcase
		end
	end

	// Cache control state: valid bits, high-water count, counters and tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			hw_q       <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			tick_q     <= '0;
			idx_q      <= '0;
			have_q     <= 1'b0;
			res_hit_q  <= 1'b0;
			res_bit_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q     <= '0;
					have_q    <= 1'b0;
					res_hit_q <= 1'b0;
					res_bit_q <= 1'b0;
					if (in_acc && (cmd_t'(cmd) == CMD_CLEAR)) begin
						valid_q    <= '0;
						hw_q       <= '0;
						hit_cnt_q  <= '0;
						miss_cnt_q <= '0;
					end
				end
				ST_LOOK_RD: begin
					if (scan_end) begin
						miss_cnt_q <= miss_cnt_q + CNT_W'(1);
					end
				end
				ST_LOOK_CMP: begin
					if (cur_valid && cmp_true) begin
						hit_cnt_q <= hit_cnt_q + CNT_W'(1);
						res_hit_q <= 1'b1;
						res_bit_q <= rdata.result;
					end else begin
						idx_q <= idx_q + HW_W'(1);
					end
				end
				ST_EVICT_CMP: begin
					// The first slot with the strictly smallest stamp wins.
					if (cur_valid && (!have_q || cmp_true)) begin
						have_q <= 1'b1;
					end
					idx_q <= idx_q + HW_W'(1);
				end
				ST_EVICT_DROP: begin
					if (have_q) begin
						valid_q[pick_q] <= 1'b0;
					end
				end
				ST_FILL: begin
					if (fill_found) begin
						valid_q[fill_idx] <= 1'b1;
						if (HW_W'(fill_idx) >= hw_q) begin
							hw_q <= HW_W'(fill_idx) + HW_W'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						tick_q <= tick_q + STAMP_W'(1);
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// Item capture and eviction candidate; payload only.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q <= key_tag[KEY_BITS-1:0];
			val_q <= store_value;
		end
		if (state_q == ST_EVICT_CMP && cur_valid && (!have_q || cmp_true)) begin
			pick_q <= idx_q[IDX_W-1:0];
			best_q <= rdata.stamp;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_hit_q    <= res_hit_q;
			out_bit_q    <= res_bit_q;
			out_hits_q   <= hit_cnt_q;
			out_misses_q <= miss_cnt_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = out_hit_q;
	assign result_bit    = out_bit_q;
	assign hits_so_far   = out_hits_q;
	assign misses_so_far = out_misses_q;

endmodule

/* src/arclru_store.sv */
// Entry memory: one write port and one registered read port.
module arclru_store
	import arclru_pkg::*;
(
	input  logic       clk,
	input  store_req_t req,
	output entry_t     rdata
);

	entry_t mem [ENTRIES];
	entry_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/arclru_cmp.sv */
// Shared compare unit: key equality or unsigned stamp ordering.
module arclru_cmp
	import arclru_pkg::*;
(
	input  cmp_req_t req,
	output logic     result
);

	always_comb begin
		case (req.op)
			CMP_KEY_EQ:   result = (req.key_a == req.key_b);
			CMP_STAMP_LT: result = (req.stamp_a < req.stamp_b);
			default:      result = 1'b0;
		endcase
	end

endmodule

/* tb/assoc_result_cache_lru_test.sv */
// Self-checking testbench for the associative result cache with LRU eviction.
`timescale 1ns / 1ps

module assoc_result_cache_lru_test;
	import arclru_pkg::*;

	// One expected result word.
	typedef struct {
		logic             hit;
		logic             data;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
	} answer_t;

	// Mirror of the cache contents, counters and registers, plus the answers still owed.
	class lru_cache_mirror;
		bit                  slot_valid [ENTRIES];
		logic [KEY_BITS-1:0] slot_key   [ENTRIES];
		logic                slot_data  [ENTRIES];
		logic [STAMP_W-1:0]  slot_stamp [ENTRIES];
		int unsigned         fill_mark;
		logic [CNT_W-1:0]    hit_cnt;
		logic [CNT_W-1:0]    miss_cnt;
		logic [STAMP_W-1:0]  tick;
		logic                enable;
		logic [CAP_W-1:0]    cap;
		answer_t             answers_due [$];
		int                  accepted;
		int                  faults;

		function new();
			enable = ENABLE_RST;
			cap = CAPACITY_RST;
			fill_mark = 0;
			hit_cnt = '0;
			miss_cnt = '0;
			tick = '0;
			accepted = 0;
			faults = 0;
			foreach (slot_valid[i]) slot_valid[i] = 1'b0;
		endfunction

		function void set_register(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
			if (r == REG_ENABLE) enable = v[0];
			else cap = v[CAP_W-1:0];
		endfunction

		// Apply one accepted request word and queue the answer it should produce.
		function void note_request(cmd_t op, logic [KEY_PORT_W-1:0] k, logic v);
			answer_t             a;
			int                  lim;
			int                  pick;
			bit                  have;
			logic [STAMP_W-1:0]  best;
			logic [KEY_BITS-1:0] key;
			key = k[KEY_BITS-1:0];
			lim = (fill_mark < ENTRIES) ? int'(fill_mark) : ENTRIES;
			a.hit = 1'b0;
			a.data = 1'b0;
			if (op == CMD_GET && enable) begin
				// The lowest matching slot wins when keys are duplicated.
				pick = -1;
				for (int i = 0; i < lim; i++)
					if (pick < 0 && slot_valid[i] && slot_key[i] == key) pick = i;
				if (pick >= 0) begin
					slot_stamp[pick] = tick;
					hit_cnt++;
					a.hit = 1'b1;
					a.data = slot_data[pick];
				end else begin
					miss_cnt++;
				end
			end else if (op == CMD_SET && enable) begin
				// Evict the first slot with the strictly smallest stamp.
				if (fill_mark >= cap) begin
					have = 1'b0;
					pick = 0;
					best = '0;
					for (int i = 0; i < lim; i++) begin
						if (slot_valid[i] && (!have || slot_stamp[i] < best)) begin
							have = 1'b1;
							pick = i;
							best = slot_stamp[i];
						end
					end
					if (have) slot_valid[pick] = 1'b0;
				end
				// Fill the first free slot, if there is one.
				pick = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (pick < 0 && !slot_valid[i]) pick = i;
				if (pick >= 0) begin
					slot_key[pick] = key;
					slot_data[pick] = v;
					slot_stamp[pick] = tick;
					slot_valid[pick] = 1'b1;
					if (pick >= int'(fill_mark)) fill_mark = pick + 1;
				end
			end else if (op == CMD_CLEAR) begin
				foreach (slot_valid[i]) slot_valid[i] = 1'b0;
				fill_mark = 0;
				hit_cnt = '0;
				miss_cnt = '0;
			end
			tick++;
			a.hits = hit_cnt;
			a.misses = miss_cnt;
			answers_due.push_back(a);
			accepted++;
		endfunction

		// Compare one accepted result word with the oldest expected answer.
		function void check_answer(logic h, logic d, logic [CNT_W-1:0] hs,
				logic [CNT_W-1:0] ms);
			answer_t want;
			if (answers_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: result word with nothing outstanding", $realtime);
				return;
			end
			want = answers_due.pop_front();
			if (want.hit !== h || want.data !== d || want.hits !== hs || want.misses !== ms) begin
				faults++;
				if (faults <= 10)
					$display("%0t: mismatch: expected hit=%0b bit=%0b hits=%0d misses=%0d, got hit=%0b bit=%0b hits=%0d misses=%0d",
						$realtime, want.hit, want.data, want.hits, want.misses,
						h, d, hs, ms);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            cmd = 2'b00;
	logic [KEY_PORT_W-1:0] key_tag = '0;
	logic                  store_value = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  hit;
	logic                  result_bit;
	logic [CNT_W-1:0]      hits_so_far;
	logic [CNT_W-1:0]      misses_so_far;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	lru_cache_mirror       board = new();
	logic [KEY_PORT_W-1:0] key_pool [20];
	bit                    calm = 1'b0;
	int                    stall_left = 0;
	bit                    held_long = 1'b0;

	assoc_result_cache_lru uut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The run must finish well within this time.
	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	// Result side: check each accepted word, then choose the next ready value.
	// One long hold-off lets the request side back up against a full block.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_answer(hit, result_bit, hits_so_far, misses_so_far);
		if (!held_long && board.accepted >= 150) begin
			held_long = 1'b1;
			stall_left = 400;
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(0, 13);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Offer one request word, after an optional idle burst, and wait until it is taken.
	task automatic send_word(input cmd_t op, input logic [KEY_PORT_W-1:0] k, input logic v);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		key_tag <= k;
		store_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_request(op, k, v);
	endtask

	// Drain all outstanding answers, then write both registers.
	task automatic reconfigure(input logic en, input logic [CAP_W-1:0] capv);
		in_valid <= 1'b0;
		while (board.answers_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_ENABLE;
		cfg_data <= CFG_DATA_W'(en);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_register(REG_ENABLE, CFG_DATA_W'(en));
		cfg_index <= REG_CAPACITY;
		cfg_data <= capv;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_register(REG_CAPACITY, capv);
		cfg_valid <= 1'b0;
	endtask

	// Mostly gets and sets over a small key pool, so hits and evictions are common.
	task automatic random_word(input int clear_pct, output cmd_t op,
			output logic [KEY_PORT_W-1:0] k, output logic v);
		int r;
		r = $urandom_range(0, 99);
		if (r < clear_pct) op = CMD_CLEAR;
		else if (r < clear_pct + 5) op = CMD_NOP;
		else if (r < 52) op = CMD_GET;
		else op = CMD_SET;
		r = $urandom_range(0, 99);
		if (r < 85) k = key_pool[$urandom_range(0, 19)];
		else if (r < 95) k = {$urandom, $urandom};
		else if (r < 97) k = '0;
		else k = '1;
		v = 1'($urandom_range(0, 1));
	endtask

	task automatic run_phase(input logic en, input logic [CAP_W-1:0] capv, input int count,
			input int clear_pct);
		cmd_t                  op;
		logic [KEY_PORT_W-1:0] k;
		logic                  v;
		reconfigure(en, capv);
		repeat (count) begin
			random_word(clear_pct, op, k, v);
			send_word(op, k, v);
		end
	endtask

	initial begin
		for (int i = 0; i < 20; i++) key_pool[i] = {$urandom, $urandom};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: miss on empty, extreme keys, duplicate keys, no-op, clear.
		send_word(CMD_GET, '0, 1'b0);
		send_word(CMD_SET, '0, 1'b1);
		send_word(CMD_SET, '1, 1'b0);
		send_word(CMD_GET, '0, 1'b0);
		send_word(CMD_GET, '1, 1'b1);
		send_word(CMD_SET, '0, 1'b0);
		send_word(CMD_GET, '0, 1'b0);
		send_word(CMD_NOP, key_pool[3], 1'b1);
		send_word(CMD_CLEAR, key_pool[4], 1'b1);
		send_word(CMD_GET, '0, 1'b0);

		// Zero capacity: every set first evicts the oldest entry, if there is one.
		reconfigure(1'b1, CAP_W'(0));
		send_word(CMD_SET, key_pool[0], 1'b1);
		send_word(CMD_SET, key_pool[1], 1'b0);
		send_word(CMD_GET, key_pool[0], 1'b0);
		send_word(CMD_GET, key_pool[1], 1'b0);

		// Disabled: get and set do nothing, but clear still works.
		reconfigure(1'b0, CAP_W'(0));
		send_word(CMD_GET, key_pool[1], 1'b0);
		send_word(CMD_SET, key_pool[2], 1'b1);
		send_word(CMD_CLEAR, '0, 1'b0);
		reconfigure(1'b1, CAP_W'(16));
		send_word(CMD_GET, key_pool[1], 1'b0);

		// Random phases over a spread of settings; the full-capacity one keeps clears rare
		// so the store fills past every slot.
		run_phase(1'b1, CAP_W'(16), 300, 3);
		run_phase(1'b1, CAP_W'(0), 150, 3);
		run_phase(1'b1, CAP_W'(1), 150, 3);
		run_phase(1'b1, CAP_W'(4), 250, 3);
		run_phase(1'b0, CAP_W'(4), 100, 3);
		run_phase(1'b1, CAP_W'(31), 250, 1);
		run_phase(1'b1, CAP_W'(2), 150, 3);
		calm = 1'b1;
		run_phase(1'b1, CAP_W'(16), 430, 3);

		in_valid <= 1'b0;
		while (board.answers_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (board.faults == 0 && board.answers_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
